@@ rtl/imusb_pkg.sv @@
// ----------------------------------------------------------------------------
// imusb_pkg
// Shared widths, register codes, sequencer step codes and lane control types
// for the six-axis biquad low-pass unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imusb_pkg;

  // sample and coefficient formats
  localparam int CHANNELS        = 6;
  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 18;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int SCALE_W         = 24;
  localparam int SCALE_FRAC_BITS = 22;
  localparam int Y_W             = 32;

  // multiplier: Y_W x SCALE_W signed, covers every tap and the output gain
  localparam int PROD_W = Y_W + SCALE_W;
  // five coefficient x history products, with growth for the sum
  localparam int ACC_W  = Y_W + COEF_W + 3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SCALE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_SCALE = 3'd5
  } cfg_reg_e;

  // reset values: 30 Hz butterworth at 500 Hz, unity dc gain
  localparam logic signed [COEF_W-1:0]  B0_RST    = 18'sd16384;
  localparam logic signed [COEF_W-1:0]  B1_RST    = 18'sd32768;
  localparam logic signed [COEF_W-1:0]  B2_RST    = 18'sd16384;
  localparam logic signed [COEF_W-1:0]  A1_RST    = 18'sd24174;
  localparam logic signed [COEF_W-1:0]  A2_RST    = -18'sd9616;
  localparam logic signed [SCALE_W-1:0] SCALE_RST = 24'sd116853;

  // rounding offsets, half an lsb of the dropped fraction
  localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (SCALE_FRAC_BITS - 1);

  // sequencer steps, one per cycle, holding at ST_OUT while the output register is full
  typedef enum logic [3:0] {
    ST_TAP_B0,
    ST_TAP_B1,
    ST_TAP_B2,
    ST_TAP_A1,
    ST_TAP_A2,
    ST_ACC_LAST,
    ST_ROUND,
    ST_SCALE,
    ST_OUT
  } step_e;

  typedef struct packed {
    logic signed [COEF_W-1:0]  b0;
    logic signed [COEF_W-1:0]  b1;
    logic signed [COEF_W-1:0]  b2;
    logic signed [COEF_W-1:0]  a1;
    logic signed [COEF_W-1:0]  a2;
    logic signed [SCALE_W-1:0] scale;
  } coef_t;

  typedef struct packed {
    logic  load;      // capture a new item into the lanes
    logic  run;       // sequencer is stepping
    step_e step;
    logic  out_load;  // lane results go to the output register
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ rtl/imusb_lane.sv @@
// ----------------------------------------------------------------------------
// imusb_lane
// One channel: direct form I biquad with a shared multiplier stepped over the
// five taps, then output gain, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module imusb_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  imusb_pkg::lane_ctl_t                 ctl_i,
  input  imusb_pkg::coef_t                     coef_i,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0] x_i,
  output logic signed [imusb_pkg::SAMPLE_W-1:0] res_o
);

  localparam int SW = imusb_pkg::SAMPLE_W;
  localparam int YW = imusb_pkg::Y_W;
  localparam int CW = imusb_pkg::COEF_W;
  localparam int KW = imusb_pkg::SCALE_W;
  localparam int PW = imusb_pkg::PROD_W;
  localparam int AW = imusb_pkg::ACC_W;

  logic signed [SW-1:0] x_q, x1_q, x2_q;
  logic signed [YW-1:0] y1_q, y2_q, y_q, y_d;
  logic signed [AW-1:0] acc_q, acc_d, acc_rnd, acc_sh;
  logic signed [PW-1:0] prod_q, prod_d, prod_rnd, prod_sh;
  logic signed [YW-1:0] mul_a;
  logic signed [KW-1:0] mul_b;
  logic                 prod_en;

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b1;
    case (ctl_i.step)
      imusb_pkg::ST_TAP_B0: begin
        mul_a = {{(YW-SW){x_q[SW-1]}}, x_q};
        mul_b = {{(KW-CW){coef_i.b0[CW-1]}}, coef_i.b0};
      end
      imusb_pkg::ST_TAP_B1: begin
        mul_a = {{(YW-SW){x1_q[SW-1]}}, x1_q};
        mul_b = {{(KW-CW){coef_i.b1[CW-1]}}, coef_i.b1};
      end
      imusb_pkg::ST_TAP_B2: begin
        mul_a = {{(YW-SW){x2_q[SW-1]}}, x2_q};
        mul_b = {{(KW-CW){coef_i.b2[CW-1]}}, coef_i.b2};
      end
      imusb_pkg::ST_TAP_A1: begin
        mul_a = y1_q;
        mul_b = {{(KW-CW){coef_i.a1[CW-1]}}, coef_i.a1};
      end
      imusb_pkg::ST_TAP_A2: begin
        mul_a = y2_q;
        mul_b = {{(KW-CW){coef_i.a2[CW-1]}}, coef_i.a2};
      end
      imusb_pkg::ST_SCALE: begin
        mul_a = y_q;
        mul_b = coef_i.scale;
      end
      default: prod_en = 1'b0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // accumulate the registered product one step behind the multiplier
  always_comb begin
    acc_d = acc_q;
    case (ctl_i.step)
      imusb_pkg::ST_TAP_B0:   acc_d = '0;
      imusb_pkg::ST_TAP_B1,
      imusb_pkg::ST_TAP_B2,
      imusb_pkg::ST_TAP_A1,
      imusb_pkg::ST_TAP_A2,
      imusb_pkg::ST_ACC_LAST: acc_d = acc_q + $signed(prod_q[AW-1:0]);
      default:                acc_d = acc_q;
    endcase
  end

  // section output: round half up, saturate to history width
  assign acc_rnd = acc_q + imusb_pkg::ACC_HALF;
  assign acc_sh  = acc_rnd >>> imusb_pkg::COEF_FRAC_BITS;

  always_comb begin
    if ((&acc_sh[AW-1:YW-1]) || !(|acc_sh[AW-1:YW-1])) begin
      y_d = acc_sh[YW-1:0];
    end else if (acc_sh[AW-1]) begin
      y_d = {1'b1, {(YW-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(YW-1){1'b1}}};
    end
  end

  // result: round half up, saturate to sample width
  assign prod_rnd = prod_q + imusb_pkg::PROD_HALF;
  assign prod_sh  = prod_rnd >>> imusb_pkg::SCALE_FRAC_BITS;

  always_comb begin
    if ((&prod_sh[PW-1:SW-1]) || !(|prod_sh[PW-1:SW-1])) begin
      res_o = prod_sh[SW-1:0];
    end else if (prod_sh[PW-1]) begin
      res_o = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q <= x_i;
    end
    if (ctl_i.run) begin
      acc_q <= acc_d;
      if (prod_en) begin
        prod_q <= prod_d;
      end
      if (ctl_i.step == imusb_pkg::ST_ROUND) begin
        y_q <= y_d;
      end
    end
  end

  // filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctl_i.run && (ctl_i.step == imusb_pkg::ST_ROUND)) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= y_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/imusb_ctrl.sv @@
// ----------------------------------------------------------------------------
// imusb_ctrl
// Step sequencer shared by all lanes: takes an item, walks the tap, round
// and scale steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imusb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output imusb_pkg::lane_ctl_t ctl_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e           state_q;
  imusb_pkg::step_e step_q;

  function automatic imusb_pkg::step_e next_step(input imusb_pkg::step_e s);
    imusb_pkg::step_e n;
    case (s)
      imusb_pkg::ST_TAP_B0:   n = imusb_pkg::ST_TAP_B1;
      imusb_pkg::ST_TAP_B1:   n = imusb_pkg::ST_TAP_B2;
      imusb_pkg::ST_TAP_B2:   n = imusb_pkg::ST_TAP_A1;
      imusb_pkg::ST_TAP_A1:   n = imusb_pkg::ST_TAP_A2;
      imusb_pkg::ST_TAP_A2:   n = imusb_pkg::ST_ACC_LAST;
      imusb_pkg::ST_ACC_LAST: n = imusb_pkg::ST_ROUND;
      imusb_pkg::ST_ROUND:    n = imusb_pkg::ST_SCALE;
      imusb_pkg::ST_SCALE:    n = imusb_pkg::ST_OUT;
      default:                n = imusb_pkg::ST_OUT;
    endcase
    return n;
  endfunction

  assign in_ready_o     = (state_q == S_IDLE);
  assign ctl_o.load     = in_valid_i && (state_q == S_IDLE);
  assign ctl_o.run      = (state_q == S_RUN);
  assign ctl_o.step     = step_q;
  assign ctl_o.out_load = (state_q == S_RUN) && (step_q == imusb_pkg::ST_OUT) && out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= imusb_pkg::ST_TAP_B0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            step_q  <= imusb_pkg::ST_TAP_B0;
          end
        end
        S_RUN: begin
          if (step_q == imusb_pkg::ST_OUT) begin
            // hold here while the output register is still occupied
            if (out_free_i) begin
              state_q <= S_IDLE;
            end
          end else begin
            step_q <= next_step(step_q);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/imu_six_axis_biquad_lowpass_unit.sv @@
// ----------------------------------------------------------------------------
// imu_six_axis_biquad_lowpass_unit
// Six-lane second-order low-pass for accelerometer and gyroscope samples.
// ----------------------------------------------------------------------------
// Each item carries six signed 16-bit samples (accel x/y/z, gyro x/y/z). Every
// axis runs its own direct form I biquad, y = b0*x + b1*x1 + b2*x2 + a1*y1 +
// a2*y2 with the feedback terms added, over shared Q3.14 coefficients. y is
// rounded half up, saturated to 32 bits and kept as history; the result is
// y * output_scale (Q1.22), rounded half up and saturated to 16 bits. Six lanes
// work in parallel, each stepping one multiplier through the five taps and the
// output gain. After an item is accepted, each lane walks the nine steps of its
// multiplier sequence (five taps, accumulate, round, gain, output) before the
// result sits in the output register; no new item is accepted until the
// sequencer is back in idle. The output register lets the next item be taken
// while the last result waits; if it is still full when a lane result is
// ready, the sequencer holds. Configuration writes take effect at once and
// belong while the block is idle. Filter history clears at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_six_axis_biquad_lowpass_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write port
  input  logic                                    cfg_we_i,
  input  logic [imusb_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [imusb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input item
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0]   accel_x_i,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0]   accel_y_i,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0]   accel_z_i,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0]   gyro_x_i,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0]   gyro_y_i,
  input  logic signed [imusb_pkg::SAMPLE_W-1:0]   gyro_z_i,
  // result item
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [imusb_pkg::SAMPLE_W-1:0]   out_accel_x_o,
  output logic signed [imusb_pkg::SAMPLE_W-1:0]   out_accel_y_o,
  output logic signed [imusb_pkg::SAMPLE_W-1:0]   out_accel_z_o,
  output logic signed [imusb_pkg::SAMPLE_W-1:0]   out_gyro_x_o,
  output logic signed [imusb_pkg::SAMPLE_W-1:0]   out_gyro_y_o,
  output logic signed [imusb_pkg::SAMPLE_W-1:0]   out_gyro_z_o
);

  localparam int NCH = imusb_pkg::CHANNELS;
  localparam int SW  = imusb_pkg::SAMPLE_W;
  localparam int CW  = imusb_pkg::COEF_W;

  // coefficient registers
  imusb_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0    <= imusb_pkg::B0_RST;
      coef_q.b1    <= imusb_pkg::B1_RST;
      coef_q.b2    <= imusb_pkg::B2_RST;
      coef_q.a1    <= imusb_pkg::A1_RST;
      coef_q.a2    <= imusb_pkg::A2_RST;
      coef_q.scale <= imusb_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imusb_pkg::REG_B0:    coef_q.b0    <= cfg_data_i[CW-1:0];
        imusb_pkg::REG_B1:    coef_q.b1    <= cfg_data_i[CW-1:0];
        imusb_pkg::REG_B2:    coef_q.b2    <= cfg_data_i[CW-1:0];
        imusb_pkg::REG_A1:    coef_q.a1    <= cfg_data_i[CW-1:0];
        imusb_pkg::REG_A2:    coef_q.a2    <= cfg_data_i[CW-1:0];
        imusb_pkg::REG_SCALE: coef_q.scale <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // sequencer
  imusb_pkg::lane_ctl_t ctl;
  logic                 out_valid_q;
  logic                 out_free;

  assign out_free = !out_valid_q || out_ready_i;

  imusb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  // lanes, in field order
  logic signed [SW-1:0] lane_x   [NCH];
  logic signed [SW-1:0] lane_res [NCH];
  logic signed [SW-1:0] res_q    [NCH];

  assign lane_x[0] = accel_x_i;
  assign lane_x[1] = accel_y_i;
  assign lane_x[2] = accel_z_i;
  assign lane_x[3] = gyro_x_i;
  assign lane_x[4] = gyro_y_i;
  assign lane_x[5] = gyro_z_i;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    imusb_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .coef_i (coef_q),
      .x_i    (lane_x[c]),
      .res_o  (lane_res[c])
    );
  end

  // merge: all lane results land together in the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      res_q <= lane_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_accel_x_o = res_q[0];
  assign out_accel_y_o = res_q[1];
  assign out_accel_z_o = res_q[2];
  assign out_gyro_x_o  = res_q[3];
  assign out_gyro_y_o  = res_q[4];
  assign out_gyro_z_o  = res_q[5];

  // checks

  // a newly taken item blocks the input until its steps are done
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("input taken again right after an item");

  // a result is never loaded in the cycle after an item is taken
  a_no_early_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !ctl.out_load
  ) else $error("result loaded before the lane steps ran");

  // lanes only overwrite the output register when it is free
  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!out_valid_q || out_ready_i)
  ) else $error("pending result overwritten");

  // a waiting result stays valid until taken; the accel x field is checked for stability
  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q[0]))
  ) else $error("pending result lost");

endmodule

`default_nettype wire
